// ----- design/csm_pkg.sv -----
// Shared types, codes and constants for the control surface mixer.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package csm_pkg;

    typedef enum logic [3:0] {
        OP_THROTTLE      = 4'd0,
        OP_RUDDER        = 4'd1,
        OP_ELEVATOR      = 4'd2,
        OP_AILERON       = 4'd3,
        OP_ELEV_TRIM     = 4'd4,
        OP_AIL_TRIM      = 4'd5,
        OP_AIL_TRIM_CLR  = 4'd6,
        OP_ELEV_TRIM_CLR = 4'd7,
        OP_FLAPS         = 4'd8,
        OP_AIRBRAKE      = 4'd9,
        OP_SAFE_RESET    = 4'd10,
        OP_MS_TICK       = 4'd11
    } opcode_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIM_STEP    = 3'd0,
        REG_TRIM_LIMIT   = 3'd1,
        REG_FLAP_ANGLE   = 3'd2,
        REG_RUDDER_HALF  = 3'd3,
        REG_LINK_TIMEOUT = 3'd4
    } cfg_reg_t;

    localparam logic [7:0] ANGLE_MAX = 8'd180;
    localparam logic [7:0] NEUTRAL   = 8'd90;
    localparam logic [7:0] FLAP_BAND = 8'd10;

    // floor(p / 90) = (p * DIV90_MULT) >> DIV90_SHIFT, exact for p < 2**15
    localparam logic [14:0] DIV90_MULT  = 15'd23302;
    localparam int unsigned DIV90_SHIFT = 21;

    typedef struct packed {
        logic [6:0]  trim_incr;
        logic [6:0]  trim_max;
        logic [4:0]  flap_gain;
        logic [6:0]  rudder_half_range;
        logic [15:0] link_timeout_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        trim_incr:         7'd2,
        trim_max:          7'd20,
        flap_gain:         5'd10,
        rudder_half_range: 7'd45,
        link_timeout_ms:   16'd1000
    };

    // Rudder is held as value * half and the half range in force when set;
    // the divide by 90 happens on the output side.
    typedef struct packed {
        logic [7:0]        engine;
        logic [7:0]        roll;
        logic [7:0]        elevator;
        logic [14:0]       rud_prod;
        logic [6:0]        rud_half;
        logic signed [7:0] elev_trim;
        logic signed [7:0] ail_trim;
        logic [6:0]        flap;
        logic              airbrake;
    } surf_state_t;

    localparam surf_state_t SAFE_STATE = '{
        engine:    8'd0,
        roll:      8'd90,
        elevator:  8'd90,
        rud_prod:  15'd0,
        rud_half:  7'd0,
        elev_trim: 8'sd0,
        ail_trim:  8'sd0,
        flap:      7'd0,
        airbrake:  1'b0
    };

    typedef struct packed {
        logic [7:0] engine_angle;
        logic [7:0] left_aileron_angle;
        logic [7:0] right_aileron_angle;
        logic [7:0] left_elevator_angle;
        logic [7:0] right_elevator_angle;
        logic [7:0] rudder_angle;
        logic       from_timeout;
    } servo_t;

    function automatic logic [7:0] clamp_angle(input logic signed [13:0] x);
        logic [7:0] r;
        if (x < 14'sd0)
            r = 8'd0;
        else if (x > $signed({6'd0, ANGLE_MAX}))
            r = ANGLE_MAX;
        else
            r = x[7:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/csm_channels.sv -----
// Handshake channels of the control surface mixer: command, servo and config.
// Depends on csm_pkg for the configuration port widths.
`timescale 1ns / 1ps
`default_nettype none

interface csm_in_if;
    logic              valid;
    logic              ready;
    logic [3:0]        opcode;
    logic [7:0]        value;
    logic signed [1:0] trim_direction;
    logic              airbrake_on;

    modport source (output valid, output opcode, output value, output trim_direction,
                    output airbrake_on, input ready);
    modport sink   (input valid, input opcode, input value, input trim_direction,
                    input airbrake_on, output ready);
endinterface

interface csm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] engine_angle;
    logic [7:0] left_aileron_angle;
    logic [7:0] right_aileron_angle;
    logic [7:0] left_elevator_angle;
    logic [7:0] right_elevator_angle;
    logic [7:0] rudder_angle;
    logic       from_timeout;

    modport source (output valid, output engine_angle, output left_aileron_angle,
                    output right_aileron_angle, output left_elevator_angle,
                    output right_elevator_angle, output rudder_angle,
                    output from_timeout, input ready);
    modport sink   (input valid, input engine_angle, input left_aileron_angle,
                    input right_aileron_angle, input left_elevator_angle,
                    input right_elevator_angle, input rudder_angle,
                    input from_timeout, output ready);
endinterface

interface csm_cfg_if import csm_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/csm_state.sv -----
// Command state of the mixer: config registers, surface commands, trims,
// link-loss counter and the pending-write flag. Depends on csm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csm_state import csm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [3:0]            opcode,
    input  logic [7:0]            value,
    input  logic signed [1:0]     trim_direction,
    input  logic                  airbrake_on,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  load,
    output cfg_t                  cfg,
    output surf_state_t           surf,
    output logic                  pend,
    output logic                  pend_timeout
);

    cfg_t        cfg_reg;
    surf_state_t surf_reg, surf_next;
    logic        link_reg, link_next;
    logic [15:0] ms_reg, ms_next;
    logic        pend_reg, pend_to_reg;
    logic        emit, emit_to;
    logic [15:0] ms_inc;
    logic        set_ok;

    function automatic logic signed [7:0] trim_update(
        input logic signed [7:0] trim,
        input logic signed [1:0] dir,
        input logic [6:0]        step,
        input logic [6:0]        lim
    );
        logic signed [8:0] sum;
        logic signed [8:0] lim_s;
        logic signed [8:0] r;
        lim_s = $signed({2'b00, lim});
        sum   = {trim[7], trim};
        if (dir > 2'sd0)
            sum = sum + $signed({2'b00, step});
        else if (dir < 2'sd0)
            sum = sum - $signed({2'b00, step});
        if (sum > lim_s)
            r = lim_s;
        else if (sum < -lim_s)
            r = -lim_s;
        else
            r = sum;
        return r[7:0];
    endfunction

    assign ms_inc = (ms_reg == 16'hFFFF) ? ms_reg : ms_reg + 16'd1;
    assign set_ok = (value <= ANGLE_MAX);

    always_comb
    begin
        surf_next = surf_reg;
        link_next = link_reg;
        ms_next   = ms_reg;
        emit      = 1'b0;
        emit_to   = 1'b0;
        case (opcode)
            OP_THROTTLE, OP_RUDDER, OP_ELEVATOR, OP_AILERON:
            begin
                // drop out-of-range set commands entirely
                if (set_ok)
                begin
                    case (opcode)
                        OP_THROTTLE: surf_next.engine = value;
                        OP_RUDDER:
                        begin
                            surf_next.rud_prod = 15'({7'd0, value}
                                               * {8'd0, cfg_reg.rudder_half_range});
                            surf_next.rud_half = cfg_reg.rudder_half_range;
                        end
                        OP_ELEVATOR: surf_next.elevator = value;
                        default:     surf_next.roll = value;
                    endcase
                    link_next = 1'b1;
                    ms_next   = 16'd0;
                    emit      = 1'b1;
                end
            end
            OP_ELEV_TRIM:
                surf_next.elev_trim = trim_update(surf_reg.elev_trim, trim_direction,
                                                  cfg_reg.trim_incr, cfg_reg.trim_max);
            OP_AIL_TRIM:
            begin
                if (trim_direction != 2'sd0)
                    surf_next.ail_trim = trim_update(surf_reg.ail_trim, trim_direction,
                                                     cfg_reg.trim_incr, cfg_reg.trim_max);
            end
            OP_AIL_TRIM_CLR:  surf_next.ail_trim = 8'sd0;
            OP_ELEV_TRIM_CLR: surf_next.elev_trim = 8'sd0;
            OP_FLAPS:
                surf_next.flap = (value > {1'b0, cfg_reg.trim_max}) ? cfg_reg.trim_max
                                                                   : value[6:0];
            OP_AIRBRAKE:      surf_next.airbrake = airbrake_on;
            OP_SAFE_RESET:
            begin
                surf_next = SAFE_STATE;
                emit      = 1'b1;
            end
            OP_MS_TICK:
            begin
                ms_next = ms_inc;
                if (link_reg && (ms_inc > cfg_reg.link_timeout_ms))
                begin
                    surf_next = SAFE_STATE;
                    link_next = 1'b0;
                    emit      = 1'b1;
                    emit_to   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= CFG_RESET;
            surf_reg    <= SAFE_STATE;
            link_reg    <= 1'b0;
            ms_reg      <= 16'd0;
            pend_reg    <= 1'b0;
            pend_to_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TRIM_STEP:    cfg_reg.trim_incr         <= cfg_data[6:0];
                    REG_TRIM_LIMIT:   cfg_reg.trim_max          <= cfg_data[6:0];
                    REG_FLAP_ANGLE:   cfg_reg.flap_gain         <= cfg_data[4:0];
                    REG_RUDDER_HALF:  cfg_reg.rudder_half_range <= cfg_data[6:0];
                    REG_LINK_TIMEOUT: cfg_reg.link_timeout_ms   <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                surf_reg    <= surf_next;
                link_reg    <= link_next;
                ms_reg      <= ms_next;
                pend_reg    <= emit;
                pend_to_reg <= emit_to;
            end
            else if (load)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    assign cfg          = cfg_reg;
    assign surf         = surf_reg;
    assign pend         = pend_reg;
    assign pend_timeout = pend_to_reg;

endmodule

`default_nettype wire

// ----- design/csm_mix.sv -----
// Servo mixing: aileron/flap/airbrake mix, elevator inversion, rudder
// scaling by 1/90 and clamping to 0..180. Depends on csm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csm_mix import csm_pkg::*; (
    input  cfg_t        cfg,
    input  surf_state_t surf,
    input  logic        from_timeout,
    output servo_t      servo
);

    logic signed [13:0] roll_trim;
    logic signed [13:0] flap_deg;
    logic signed [13:0] left_mix, right_mix;
    logic signed [13:0] elev_sum;
    logic [29:0]        rud_scaled;
    logic [8:0]         rud_quot;
    logic signed [13:0] rud_pos;
    logic               near_neutral;

    always_comb
    begin
        roll_trim    = $signed({6'd0, surf.roll}) + 14'(surf.ail_trim);
        flap_deg     = $signed({2'b00, 12'({5'd0, surf.flap} * {7'd0, cfg.flap_gain})});
        near_neutral = surf.roll inside {[NEUTRAL - FLAP_BAND + 8'd1 : NEUTRAL + FLAP_BAND - 8'd1]};
        left_mix     = roll_trim;
        right_mix    = roll_trim;
        if (near_neutral)
        begin
            left_mix  = roll_trim + flap_deg;
            right_mix = roll_trim - flap_deg;
        end
        // airbrake drives both ailerons to full travel
        if (surf.airbrake)
        begin
            left_mix  = 14'sd0;
            right_mix = 14'sd0;
        end

        elev_sum = $signed({6'd0, surf.elevator}) + 14'(surf.elev_trim);

        rud_scaled = {15'd0, surf.rud_prod} * {15'd0, DIV90_MULT};
        rud_quot   = rud_scaled[DIV90_SHIFT +: 9];
        rud_pos    = $signed({6'd0, NEUTRAL}) + $signed({5'd0, rud_quot})
                   - $signed({7'd0, surf.rud_half});

        servo.engine_angle         = clamp_angle($signed({6'd0, surf.engine}));
        servo.left_aileron_angle   = clamp_angle($signed({6'd0, ANGLE_MAX}) - left_mix);
        servo.right_aileron_angle  = clamp_angle($signed({6'd0, ANGLE_MAX}) - right_mix);
        servo.left_elevator_angle  = clamp_angle(elev_sum);
        servo.right_elevator_angle = clamp_angle($signed({6'd0, ANGLE_MAX}) - elev_sum);
        servo.rudder_angle         = clamp_angle(rud_pos);
        servo.from_timeout         = from_timeout;
    end

endmodule

`default_nettype wire

// ----- design/control_surface_mixer_unit.sv -----
// Control surface mixer, top level: command, servo and config channels.
// Depends on csm_pkg, csm_channels, csm_state and csm_mix.
//
// Usage:
//   cmd carries one command item per handshake (stick set, trim step, flaps,
//   airbrake, safe reset or millisecond tick). Items that write the servos
//   produce one item on servo: the state registers take the command at
//   the accepting edge, the mix and the rudder divide-by-90 multiplier
//   run combinationally on those registers, and the result is registered
//   in the servo output register once it is free. Other commands produce nothing.
//   Throughput is one command per cycle while servo is not stalled; the
//   output register plus a one-deep pending flag decouple the two sides.
//   When servo stalls with a result held and another result pending,
//   cmd.ready drops until the output register drains.
//   cfg is always ready; write it only while no command is in flight.
//   Reset (rst_n low, asynchronous) loads the default config and safe
//   surface positions, clears the link state and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module control_surface_mixer_unit import csm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    csm_in_if.sink     cmd,
    csm_out_if.source  servo,
    csm_cfg_if.sink    cfg
);

    cfg_t        cfg_cur;
    surf_state_t surf;
    logic        pend;
    logic        pend_timeout;
    logic        load_out;
    logic        cmd_accept;
    servo_t      mixed_servo;
    servo_t      servo_reg;
    logic        out_valid_reg;

    assign load_out   = pend && (!out_valid_reg || servo.ready);
    assign cmd.ready  = !pend || load_out;
    assign cmd_accept = cmd.valid && cmd.ready;
    assign cfg.ready  = 1'b1;

    csm_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (cmd_accept),
        .opcode         (cmd.opcode),
        .value          (cmd.value),
        .trim_direction (cmd.trim_direction),
        .airbrake_on    (cmd.airbrake_on),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .load           (load_out),
        .cfg            (cfg_cur),
        .surf           (surf),
        .pend           (pend),
        .pend_timeout   (pend_timeout)
    );

    csm_mix u_mix (
        .cfg          (cfg_cur),
        .surf         (surf),
        .from_timeout (pend_timeout),
        .servo        (mixed_servo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (servo.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            servo_reg <= mixed_servo;
    end

    assign servo.valid                = out_valid_reg;
    assign servo.engine_angle         = servo_reg.engine_angle;
    assign servo.left_aileron_angle   = servo_reg.left_aileron_angle;
    assign servo.right_aileron_angle  = servo_reg.right_aileron_angle;
    assign servo.left_elevator_angle  = servo_reg.left_elevator_angle;
    assign servo.right_elevator_angle = servo_reg.right_elevator_angle;
    assign servo.rudder_angle         = servo_reg.rudder_angle;
    assign servo.from_timeout         = servo_reg.from_timeout;

    // hold the surface state while a result waits to be mixed
    a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pend && !load_out) |=> $stable(surf))
        else $error("surface state changed under a pending result");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (servo_reg.engine_angle <= ANGLE_MAX
                        && servo_reg.left_aileron_angle <= ANGLE_MAX
                        && servo_reg.right_aileron_angle <= ANGLE_MAX
                        && servo_reg.left_elevator_angle <= ANGLE_MAX
                        && servo_reg.right_elevator_angle <= ANGLE_MAX
                        && servo_reg.rudder_angle <= ANGLE_MAX))
        else $error("servo angle out of range");

    a_timeout_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && servo_reg.from_timeout) |->
            (servo_reg.engine_angle == 8'd0
          && servo_reg.rudder_angle == NEUTRAL
          && servo_reg.left_elevator_angle == NEUTRAL
          && servo_reg.right_elevator_angle == NEUTRAL
          && servo_reg.left_aileron_angle == NEUTRAL
          && servo_reg.right_aileron_angle == NEUTRAL))
        else $error("link-loss result not at safe positions");

    a_pend_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pend && !out_valid_reg) |=> (out_valid_reg && !$stable(servo_reg.from_timeout)
                                      || out_valid_reg))
        else $error("pending result not moved to output register");

endmodule

`default_nettype wire

// ----- dv/csm_servo_checker.sv -----
// Scoreboard for the control surface mixer: follows the command and config
// channels, predicts every servo item and checks each one in order.
// Depends on csm_pkg and the channel interfaces in csm_channels.
`timescale 1ns / 1ps

module csm_servo_checker import csm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    csm_in_if           cmd,
    csm_out_if          servo,
    csm_cfg_if          cfg,
    output int unsigned mismatches,
    output int unsigned servo_due,
    output int unsigned servo_checked,
    output int unsigned shutdowns
);

    localparam int MID_DEG  = int'(NEUTRAL);
    localparam int FULL_DEG = int'(ANGLE_MAX);
    localparam int BAND_DEG = int'(FLAP_BAND);

    cfg_t        regs;
    int          engine_deg;
    int          roll_deg;
    int          elevator_deg;
    int          rudder_deg;
    int          elev_trim;
    int          ail_trim;
    int          flap_units;
    bit          brake_out;
    bit          link_up;
    int unsigned ms_quiet;
    servo_t      servo_expected[$];

    function automatic int clamp_int(int x, int lo, int hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function void park_surfaces();
        engine_deg   = 0;
        roll_deg     = MID_DEG;
        elevator_deg = MID_DEG;
        rudder_deg   = MID_DEG;
        elev_trim    = 0;
        ail_trim     = 0;
        flap_units   = 0;
        brake_out    = 1'b0;
    endfunction

    function automatic int trim_move(int trim, int dir);
        int lim;
        lim = int'(regs.trim_max);
        if (dir > 0)
            trim += int'(regs.trim_incr);
        else if (dir < 0)
            trim -= int'(regs.trim_incr);
        return clamp_int(trim, -lim, lim);
    endfunction

    function automatic servo_t mix_servos(bit timed_out);
        servo_t s;
        int     left;
        int     right;
        int     dev;
        int     lift;
        left  = roll_deg + ail_trim;
        right = left;
        dev   = roll_deg - MID_DEG;
        if (dev < 0)
            dev = -dev;
        // flaps only mix in while roll sits close to neutral
        if (dev < BAND_DEG)
        begin
            lift   = flap_units * int'(regs.flap_gain);
            left  += lift;
            right -= lift;
        end
        if (brake_out)
        begin
            left  = 0;
            right = 0;
        end
        s.engine_angle         = 8'(clamp_int(engine_deg, 0, FULL_DEG));
        s.left_aileron_angle   = 8'(clamp_int(FULL_DEG - left, 0, FULL_DEG));
        s.right_aileron_angle  = 8'(clamp_int(FULL_DEG - right, 0, FULL_DEG));
        s.left_elevator_angle  = 8'(clamp_int(elevator_deg + elev_trim, 0, FULL_DEG));
        s.right_elevator_angle = 8'(clamp_int(FULL_DEG - elevator_deg - elev_trim, 0, FULL_DEG));
        s.rudder_angle         = 8'(clamp_int(rudder_deg, 0, FULL_DEG));
        s.from_timeout         = timed_out;
        return s;
    endfunction

    function void predict_command(logic [3:0] op, logic [7:0] v, logic signed [1:0] d,
                                  logic brake_in);
        int val;
        int dir;
        int half;
        val  = int'(v);
        dir  = int'(d);
        half = int'(regs.rudder_half_range);
        case (op)
            OP_THROTTLE, OP_RUDDER, OP_ELEVATOR, OP_AILERON:
            begin
                // out-of-range angles are dropped without touching the link
                if (val <= FULL_DEG)
                begin
                    if (op == OP_THROTTLE)
                        engine_deg = val;
                    else if (op == OP_RUDDER)
                        rudder_deg = clamp_int(val * 2 * half / 180 + MID_DEG - half,
                                               0, FULL_DEG);
                    else if (op == OP_ELEVATOR)
                        elevator_deg = val;
                    else
                        roll_deg = val;
                    ms_quiet = 0;
                    link_up  = 1'b1;
                    servo_expected.push_back(mix_servos(1'b0));
                end
            end
            OP_ELEV_TRIM:
                elev_trim = trim_move(elev_trim, dir);
            OP_AIL_TRIM:
            begin
                if (dir != 0)
                    ail_trim = trim_move(ail_trim, dir);
            end
            OP_AIL_TRIM_CLR:
                ail_trim = 0;
            OP_ELEV_TRIM_CLR:
                elev_trim = 0;
            OP_FLAPS:
                flap_units = clamp_int(val, 0, int'(regs.trim_max));
            OP_AIRBRAKE:
                brake_out = brake_in;
            OP_SAFE_RESET:
            begin
                park_surfaces();
                servo_expected.push_back(mix_servos(1'b0));
            end
            OP_MS_TICK:
            begin
                if (ms_quiet < 32'hFFFF)
                    ms_quiet++;
                if (link_up && ms_quiet > regs.link_timeout_ms)
                begin
                    park_surfaces();
                    link_up = 1'b0;
                    servo_expected.push_back(mix_servos(1'b1));
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function void check_field(string name, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t servo %s: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function void check_servo();
        servo_t want;
        if (servo_expected.size() == 0)
        begin
            mismatches++;
            $display("%0t servo item with nothing expected: expected none, %s",
                     $time, "got");
            $display("    %0d %0d %0d %0d %0d %0d %0d",
                     servo.engine_angle, servo.left_aileron_angle,
                     servo.right_aileron_angle, servo.left_elevator_angle,
                     servo.right_elevator_angle, servo.rudder_angle, servo.from_timeout);
            return;
        end
        want = servo_expected.pop_front();
        check_field("engine_angle", want.engine_angle, servo.engine_angle);
        check_field("left_aileron_angle", want.left_aileron_angle, servo.left_aileron_angle);
        check_field("right_aileron_angle", want.right_aileron_angle, servo.right_aileron_angle);
        check_field("left_elevator_angle", want.left_elevator_angle, servo.left_elevator_angle);
        check_field("right_elevator_angle", want.right_elevator_angle,
                    servo.right_elevator_angle);
        check_field("rudder_angle", want.rudder_angle, servo.rudder_angle);
        check_field("from_timeout", want.from_timeout, servo.from_timeout);
        servo_checked++;
        if (want.from_timeout)
            shutdowns++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = CFG_RESET;
            park_surfaces();
            link_up  = 1'b0;
            ms_quiet = 0;
            servo_expected.delete();
            mismatches    = 0;
            servo_checked = 0;
            shutdowns     = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_TRIM_STEP:    regs.trim_incr         = cfg.data[6:0];
                    REG_TRIM_LIMIT:   regs.trim_max          = cfg.data[6:0];
                    REG_FLAP_ANGLE:   regs.flap_gain         = cfg.data[4:0];
                    REG_RUDDER_HALF:  regs.rudder_half_range = cfg.data[6:0];
                    REG_LINK_TIMEOUT: regs.link_timeout_ms   = cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            if (servo.valid && servo.ready)
                check_servo();
            if (cmd.valid && cmd.ready)
                predict_command(cmd.opcode, cmd.value, cmd.trim_direction, cmd.airbrake_on);
        end
        servo_due = servo_expected.size();
    end

endmodule

// ----- dv/control_surface_mixer_unit_test.sv -----
// Top of the control surface mixer testbench: clock, reset, command and
// config stimulus, servo back-pressure and the verdict.
// Depends on csm_pkg, csm_channels, the mixer RTL and csm_servo_checker.
`timescale 1ns / 1ps

module control_surface_mixer_unit_test;
    import csm_pkg::*;

    localparam int          RESET_CYCLES   = 5;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          RX_HOLD_CYCLES = 200;
    localparam int          HOLD_SETS      = 12;
    localparam int          PHASES         = 10;
    localparam int unsigned CYCLE_LIMIT    = 200_000;

    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    logic        clk;
    logic        rst_n;
    bit          tx_gaps;
    bit          rx_gaps;
    bit          rx_hold_req;
    int          cur_limit;
    int          cur_timeout;
    int unsigned items_sent;
    int unsigned settings_used;
    int unsigned cycles;
    int unsigned fail_count;
    int unsigned servo_due;
    int unsigned servo_checked;
    int unsigned shutdowns;

    csm_in_if  cmd_ch ();
    csm_out_if servo_ch ();
    csm_cfg_if cfg_ch ();

    control_surface_mixer_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .servo (servo_ch),
        .cfg   (cfg_ch)
    );

    csm_servo_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_ch),
        .servo         (servo_ch),
        .cfg           (cfg_ch),
        .mismatches    (fail_count),
        .servo_due     (servo_due),
        .servo_checked (servo_checked),
        .shutdowns     (shutdowns)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t watchdog expired after %0d cycles, %0d servo items outstanding",
                     $time, cycles, servo_due);
            $display("status: fail");
            $finish;
        end
    end

    // servo side: short random stalls, or one long hold when asked
    initial
    begin
        servo_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                servo_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
                servo_ch.ready <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(0, 4) == 0)
            begin
                servo_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                servo_ch.ready <= 1'b1;
            end
            else
                servo_ch.ready <= 1'b1;
        end
    end

    // Returns at the falling edge after acceptance with valid still high.
    task automatic send_cmd(logic [3:0] op, logic [7:0] v, logic signed [1:0] d, logic b);
        if (tx_gaps && $urandom_range(0, 4) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.opcode         <= op;
        cmd_ch.value          <= v;
        cmd_ch.trim_direction <= d;
        cmd_ch.airbrake_on    <= b;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_set();
        send_cmd(4'($urandom_range(OP_THROTTLE, OP_AILERON)), 8'($urandom_range(0, 180)),
                 2'($urandom), 1'($urandom));
    endtask

    // Drop valid and hold until every predicted servo item has been taken.
    task automatic wait_for_servos();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (servo_due != 0);
    endtask

    task automatic wait_idle();
        wait_for_servos();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(int step, int limit, int fangle, int half, int timeout);
        logic [15:0] vals [5];
        cfg_reg_t    idx  [5];
        vals = '{16'(step), 16'(limit), 16'(fangle), 16'(half), 16'(timeout)};
        idx  = '{REG_TRIM_STEP, REG_TRIM_LIMIT, REG_FLAP_ANGLE, REG_RUDDER_HALF,
                 REG_LINK_TIMEOUT};
        for (int i = 0; i < 5; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
        cur_limit   = limit;
        cur_timeout = timeout;
        settings_used++;
    endtask

    task automatic random_item();
        int          pick;
        int          run;
        logic [7:0]  v;
        logic [1:0]  d;
        logic        b;
        pick = $urandom_range(0, 99);
        v    = 8'($urandom);
        d    = 2'($urandom);
        b    = 1'($urandom);
        if (pick < 44)
        begin
            if ($urandom_range(0, 9) != 0)
                v = 8'($urandom_range(0, 180));
            else
                v = 8'($urandom_range(181, 255));
            send_cmd(4'($urandom_range(OP_THROTTLE, OP_AILERON)), v, d, b);
        end
        else if (pick < 54)
            send_cmd(OP_ELEV_TRIM, v, d, b);
        else if (pick < 62)
            send_cmd(OP_AIL_TRIM, v, d, b);
        else if (pick < 65)
            send_cmd(OP_AIL_TRIM_CLR, v, d, b);
        else if (pick < 68)
            send_cmd(OP_ELEV_TRIM_CLR, v, d, b);
        else if (pick < 74)
        begin
            if ($urandom_range(0, 1) != 0)
                v = 8'($urandom_range(0, cur_limit + 4));
            send_cmd(OP_FLAPS, v, d, b);
        end
        else if (pick < 80)
            send_cmd(OP_AIRBRAKE, v, d, b);
        else if (pick < 83)
            send_cmd(OP_SAFE_RESET, v, d, b);
        else if (pick < 86)
            send_cmd(4'($urandom_range(int'(OP_MS_TICK) + 1, 15)), v, d, b);
        else if (pick < 96)
            send_cmd(OP_MS_TICK, v, d, b);
        else
        begin
            // a run of ticks that can let the link drop when the timeout is short
            run = (cur_timeout <= 64) ? $urandom_range(1, cur_timeout + 3)
                                      : $urandom_range(1, 8);
            repeat (run) send_cmd(OP_MS_TICK, 8'($urandom), 2'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_phase(int unsigned quota, bit with_hold);
        int unsigned stop_at;
        int unsigned mid;
        stop_at = items_sent + quota;
        mid     = items_sent + quota / 2;
        while (items_sent < mid)
            random_item();
        if (with_hold)
        begin
            // stall the servo side while commands keep coming
            rx_hold_req = 1'b1;
            repeat (HOLD_SETS) send_set();
        end
        else
            wait_for_servos();
        while (items_sent < stop_at)
            random_item();
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.opcode         = OP_MS_TICK;
        cmd_ch.value          = 8'd0;
        cmd_ch.trim_direction = DIR_NONE;
        cmd_ch.airbrake_on    = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_TRIM_STEP;
        cfg_ch.data           = 16'd0;
        tx_gaps               = 1'b1;
        rx_gaps               = 1'b1;
        rx_hold_req           = 1'b0;
        cur_limit             = 20;
        cur_timeout           = 1000;
        items_sent            = 0;
        settings_used         = 1;
        cycles                = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed pass under the reset register values
        send_cmd(OP_THROTTLE, 8'd0, DIR_NONE, 1'b0);
        send_cmd(OP_THROTTLE, 8'd180, DIR_NONE, 1'b0);
        send_cmd(OP_THROTTLE, 8'd181, DIR_NONE, 1'b0);
        send_cmd(OP_RUDDER, 8'd255, DIR_NONE, 1'b0);
        send_cmd(OP_RUDDER, 8'd0, DIR_NONE, 1'b0);
        send_cmd(OP_RUDDER, 8'd180, DIR_NONE, 1'b0);
        send_cmd(OP_ELEV_TRIM, 8'd0, DIR_UP, 1'b0);
        send_cmd(OP_ELEV_TRIM, 8'd0, DIR_NONE, 1'b0);
        send_cmd(OP_ELEV_TRIM, 8'd0, DIR_DOWN, 1'b0);
        send_cmd(OP_AIL_TRIM, 8'd0, DIR_UP, 1'b0);
        send_cmd(OP_AIL_TRIM, 8'd0, DIR_NONE, 1'b0);
        send_cmd(OP_FLAPS, 8'd255, DIR_NONE, 1'b0);
        send_cmd(OP_AILERON, 8'd95, DIR_NONE, 1'b0);
        send_cmd(OP_AILERON, 8'd80, DIR_NONE, 1'b0);
        send_cmd(OP_AILERON, 8'd100, DIR_NONE, 1'b0);
        send_cmd(OP_AIRBRAKE, 8'd0, DIR_NONE, 1'b1);
        send_cmd(OP_ELEVATOR, 8'd0, DIR_NONE, 1'b0);
        send_cmd(OP_ELEVATOR, 8'd180, DIR_NONE, 1'b0);
        send_cmd(OP_AIRBRAKE, 8'd0, DIR_NONE, 1'b0);
        send_cmd(OP_AIL_TRIM_CLR, 8'd0, DIR_NONE, 1'b0);
        send_cmd(OP_ELEV_TRIM_CLR, 8'd0, DIR_NONE, 1'b0);
        send_cmd(OP_SAFE_RESET, 8'd0, DIR_NONE, 1'b0);
        send_cmd(4'hF, 8'd90, DIR_UP, 1'b1);
        send_cmd(OP_MS_TICK, 8'd0, DIR_NONE, 1'b0);
        run_phase(140, 1'b1);

        for (int p = 1; p <= PHASES; p++)
        begin
            wait_idle();
            case (p)
                1:       set_config(1, 0, 0, 0, 1);
                2:       set_config(90, 90, 30, 90, 65535);
                3:       set_config(7, 45, 17, 127, 10);
                default: set_config(($urandom_range(0, 3) == 0) ? $urandom_range(1, 90)
                                                                 : $urandom_range(1, 10),
                                    $urandom_range(0, 90), $urandom_range(0, 30),
                                    $urandom_range(0, 90), $urandom_range(1, 40));
            endcase
            tx_gaps = (p % 3 != 1) && (p != PHASES);
            rx_gaps = (p % 3 != 2) && (p != PHASES);
            run_phase(150, (p % 2 == 0) && (p != PHASES));
        end
        wait_idle();

        $display("covered %0d commands over %0d register settings", items_sent, settings_used);
        $display("checked %0d servo items, %0d of them link-loss shutdowns", servo_checked,
                 shutdowns);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
